### rtl/pvmr_pkg.sv
`timescale 1ns / 1ps

package pvmr_pkg;

  // Mix block geometry
  localparam int BLOCK_BYTES = 32768;
  localparam int SLOT_AW     = $clog2(BLOCK_BYTES);
  localparam int SLOT_W      = $clog2(BLOCK_BYTES + 1);
  localparam int SAMP_W      = 16;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_OUT_RATE   = 2'd0;
  localparam logic [1:0] REG_OUT_WIDE   = 2'd1;
  localparam logic [1:0] REG_OUT_TWO_CH = 2'd2;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_VOICE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_ISSUE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] rate_code;
    logic       wide;
    logic       two_channel;
  } cfg_t;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [1:0]               src_rate_code;
    logic                     src_wide;
    logic                     src_two_channel;
    logic signed [SAMP_W-1:0] left_in;
    logic signed [SAMP_W-1:0] right_in;
    logic [14:0]              read_slot;
  } cmd_t;

  typedef struct packed {
    logic              accepted;
    logic [SAMP_W-1:0] read_data;
    logic [15:0]       fill_bytes;
  } res_t;

endpackage

### rtl/pcm_voice_mix_resampler_unit.sv
`timescale 1ns / 1ps

// PCM voice mixer: requests on the cmd channel clear the mix block, start a voice, add one
// source frame (converted to the output width and repeated or dropped by the power-of-two
// rate ratio) or read one slot; every request returns one result on the res channel. One
// request is worked at a time, with a result register so the next request is taken while
// the previous result waits. Cost is set by the read-modify-write of the mix store, one
// slot per cycle: a frame that fits writes 0 to 16 slots (up to 8 copies, 2 slots each
// in stereo); a refused frame, a voice start and a slot read write none; a block clear
// sweeps all BLOCK_BYTES slots (32768) of the store. After reset the same sweep runs
// before the first request is taken; configuration writes are taken at any time.
module pcm_voice_mix_resampler_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  pvmr_pkg::cmd_t               cmd,
  output logic                         res_valid,
  input  logic                         res_ready,
  output pvmr_pkg::res_t               res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pvmr_pkg::PADDR_W-1:0] paddr,
  input  logic [pvmr_pkg::PDATA_W-1:0] pwdata,
  output logic [pvmr_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  pvmr_pkg::cfg_t cfg;

  // Output format registers
  pvmr_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Mix engine with its store
  pvmr_mix_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

### rtl/pvmr_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write port, one registered read port
module pvmr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/pvmr_apb_regs.sv
`timescale 1ns / 1ps

// Output format registers behind an APB-style port
module pvmr_apb_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pvmr_pkg::PADDR_W-1:0] paddr,
  input  logic [pvmr_pkg::PDATA_W-1:0] pwdata,
  output logic [pvmr_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output pvmr_pkg::cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate_code   <= 2'd1;
      cfg.wide        <= 1'b1;
      cfg.two_channel <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        pvmr_pkg::REG_OUT_RATE:   cfg.rate_code   <= pwdata[1:0];
        pvmr_pkg::REG_OUT_WIDE:   cfg.wide        <= pwdata[0];
        pvmr_pkg::REG_OUT_TWO_CH: cfg.two_channel <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      pvmr_pkg::REG_OUT_RATE:   prdata = pvmr_pkg::PDATA_W'(cfg.rate_code);
      pvmr_pkg::REG_OUT_WIDE:   prdata = pvmr_pkg::PDATA_W'(cfg.wide);
      pvmr_pkg::REG_OUT_TWO_CH: prdata = pvmr_pkg::PDATA_W'(cfg.two_channel);
      default:                  prdata = '0;
    endcase
  end

endmodule

### rtl/pvmr_mix_engine.sv
`timescale 1ns / 1ps

// Request sequencer around the mix store: one slot read-modify-write per cycle
module pvmr_mix_engine (
  input  logic           clk,
  input  logic           rst,
  input  pvmr_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  pvmr_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output pvmr_pkg::res_t res
);

  localparam int AW = pvmr_pkg::SLOT_AW;
  localparam int SW = pvmr_pkg::SLOT_W;

  // Convert one sample to output width (17-bit signed holds every case)
  function automatic logic signed [16:0] to_out(input logic [15:0] x, input logic s_wide,
                                                input logic o_wide);
    logic signed [16:0] v;
    if (s_wide) begin
      if (o_wide) v = {x[15], x};
      else        v = {9'b0, x[15:8]};
    end else begin
      if (o_wide) v = {x[7], x[7:0], 8'b0};
      else        v = {{9{x[7]}}, x[7:0]};
    end
    return v;
  endfunction

  pvmr_pkg::state_t state, state_next;
  pvmr_pkg::cmd_t   cmd_q, cmd_q_next;
  pvmr_pkg::res_t   res_next;
  logic             res_valid_next;

  logic [SW-1:0] write_slot, write_slot_next;
  logic [2:0]    drop_count, drop_count_next;
  logic [1:0]    repeat_shift, repeat_shift_next;
  logic [1:0]    drop_shift, drop_shift_next;
  logic [1:0]    src_flags, src_flags_next;
  logic [SW-1:0] max_fill, max_fill_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic          clr_reply, clr_reply_next;
  logic [3:0]    copies, copies_next;
  logic          side, side_next;
  logic          acc, acc_next;
  logic          wb_valid, wb_valid_next;
  logic [AW-1:0] wb_addr, wb_addr_next;
  logic [15:0]   wb_val, wb_val_next;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  logic [15:0]        mask;
  logic [SW:0]        need, cap, ws_sum, bytes_after;
  logic [SW-1:0]      ws_inc;
  logic               fits;
  logic signed [16:0] l_conv, r_conv, l_rnd, r_rnd, l_half, r_half;
  logic signed [17:0] lr_sum, mono;
  logic [31:0]        rd_ext;
  logic               rd_in_range;
  logic [2:0]         drop_last;
  logic [15:0]        fill_sat;

  // Store
  pvmr_ram #(.WIDTH(16), .DEPTH(pvmr_pkg::BLOCK_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Write port: clearing sweep or mix writeback
  assign mask      = cfg.wide ? 16'hffff : 16'h00ff;
  assign ram_we    = (state == pvmr_pkg::ST_CLEAR) || wb_valid;
  assign ram_waddr = (state == pvmr_pkg::ST_CLEAR) ? clr_addr : wb_addr;
  assign ram_wdata = (state == pvmr_pkg::ST_CLEAR) ? 16'd0 : ((ram_rdata + wb_val) & mask);

  // Capacity check
  assign need   = cfg.two_channel ? (SW+1)'(2) : (SW+1)'(1);
  assign cap    = cfg.wide ? (SW+1)'(pvmr_pkg::BLOCK_BYTES / 2)
                           : (SW+1)'(pvmr_pkg::BLOCK_BYTES);
  assign ws_sum = {1'b0, write_slot} + need;
  assign fits   = (ws_sum <= cap);

  assign ws_inc      = write_slot + SW'(1);
  assign bytes_after = cfg.wide ? {ws_inc, 1'b0} : {1'b0, ws_inc};

  // Sample conversion and scaling
  assign l_conv = to_out(cmd_q.left_in, src_flags[0], cfg.wide);
  assign r_conv = src_flags[1] ? to_out(cmd_q.right_in, src_flags[0], cfg.wide) : l_conv;
  // halve, truncating toward zero
  assign l_rnd  = l_conv + $signed({16'b0, l_conv[16]});
  assign r_rnd  = r_conv + $signed({16'b0, r_conv[16]});
  assign l_half = l_rnd >>> 1;
  assign r_half = r_rnd >>> 1;
  // mono: floor of a quarter of the sum
  assign lr_sum = {l_conv[16], l_conv} + {r_conv[16], r_conv};
  assign mono   = lr_sum >>> 2;

  assign rd_ext      = 32'(cmd_q.read_slot);
  assign rd_in_range = (rd_ext < 32'(pvmr_pkg::BLOCK_BYTES));
  assign drop_last   = 3'((4'd1 << drop_shift) - 4'd1);
  assign fill_sat    = (32'(max_fill) > 32'hffff) ? 16'hffff : 16'(max_fill);

  // Sequencer
  always_comb begin
    state_next        = state;
    cmd_q_next        = cmd_q;
    res_next          = res;
    res_valid_next    = res_valid;
    write_slot_next   = write_slot;
    drop_count_next   = drop_count;
    repeat_shift_next = repeat_shift;
    drop_shift_next   = drop_shift;
    src_flags_next    = src_flags;
    max_fill_next     = max_fill;
    clr_addr_next     = clr_addr;
    clr_reply_next    = clr_reply;
    copies_next       = copies;
    side_next         = side;
    acc_next          = acc;
    wb_valid_next     = 1'b0;
    wb_addr_next      = wb_addr;
    wb_val_next       = wb_val;
    cmd_ready         = 1'b0;
    ram_re            = 1'b0;
    ram_raddr         = write_slot[AW-1:0];

    if (res_valid && res_ready) begin
      res_valid_next = 1'b0;
    end

    unique case (state)
      pvmr_pkg::ST_CLEAR: begin
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(pvmr_pkg::BLOCK_BYTES - 1)) begin
          state_next = clr_reply ? pvmr_pkg::ST_DONE : pvmr_pkg::ST_IDLE;
        end
      end

      pvmr_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_q_next = cmd;
          state_next = pvmr_pkg::ST_EXEC;
        end
      end

      pvmr_pkg::ST_EXEC: begin
        acc_next   = 1'b0;
        state_next = pvmr_pkg::ST_DONE;
        case (cmd_q.opcode)
          pvmr_pkg::OP_FRAME: begin
            if (fits) begin
              acc_next   = 1'b1;
              side_next  = 1'b0;
              state_next = pvmr_pkg::ST_ISSUE;
              if (drop_shift != 2'd0) begin
                if (drop_count >= drop_last) begin
                  drop_count_next = 3'd0;
                  copies_next     = 4'd1;
                end else begin
                  drop_count_next = drop_count + 3'd1;
                  copies_next     = 4'd0;
                end
              end else begin
                copies_next = 4'd1 << repeat_shift;
              end
            end
          end
          pvmr_pkg::OP_VOICE: begin
            write_slot_next = '0;
            drop_count_next = 3'd0;
            src_flags_next  = {cmd_q.src_two_channel, cmd_q.src_wide};
            if (cmd_q.src_rate_code > cfg.rate_code) begin
              drop_shift_next   = cmd_q.src_rate_code - cfg.rate_code;
              repeat_shift_next = 2'd0;
            end else begin
              drop_shift_next   = 2'd0;
              repeat_shift_next = cfg.rate_code - cmd_q.src_rate_code;
            end
          end
          pvmr_pkg::OP_CLEAR: begin
            write_slot_next = '0;
            drop_count_next = 3'd0;
            max_fill_next   = '0;
            clr_addr_next   = '0;
            clr_reply_next  = 1'b1;
            state_next      = pvmr_pkg::ST_CLEAR;
          end
          default: begin
            // slot read
            ram_re    = 1'b1;
            ram_raddr = rd_ext[AW-1:0];
          end
        endcase
      end

      pvmr_pkg::ST_ISSUE: begin
        if (side || (copies != 4'd0 && fits)) begin
          ram_re          = 1'b1;
          wb_valid_next   = 1'b1;
          wb_addr_next    = write_slot[AW-1:0];
          write_slot_next = ws_inc;
          if (bytes_after > {1'b0, max_fill}) begin
            max_fill_next = bytes_after[SW-1:0];
          end
          if (side) begin
            wb_val_next = r_half[15:0];
            side_next   = 1'b0;
            copies_next = copies - 4'd1;
          end else if (cfg.two_channel) begin
            wb_val_next = l_half[15:0];
            side_next   = 1'b1;
          end else begin
            wb_val_next = mono[15:0];
            copies_next = copies - 4'd1;
          end
        end else begin
          state_next = pvmr_pkg::ST_DONE;
        end
      end

      pvmr_pkg::ST_DONE: begin
        if (!res_valid || res_ready) begin
          res_valid_next      = 1'b1;
          res_next.accepted   = (cmd_q.opcode == pvmr_pkg::OP_FRAME) && acc;
          res_next.read_data  = (cmd_q.opcode == pvmr_pkg::OP_READ && rd_in_range)
                                ? (ram_rdata & mask) : 16'd0;
          res_next.fill_bytes = fill_sat;
          clr_reply_next      = 1'b0;
          state_next          = pvmr_pkg::ST_IDLE;
        end
      end

      default: state_next = pvmr_pkg::ST_IDLE;
    endcase
  end

  // Control and voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pvmr_pkg::ST_CLEAR;
      res_valid    <= 1'b0;
      write_slot   <= '0;
      drop_count   <= 3'd0;
      repeat_shift <= 2'd0;
      drop_shift   <= 2'd0;
      src_flags    <= 2'd0;
      max_fill     <= '0;
      clr_addr     <= '0;
      clr_reply    <= 1'b0;
      wb_valid     <= 1'b0;
    end else begin
      state        <= state_next;
      res_valid    <= res_valid_next;
      write_slot   <= write_slot_next;
      drop_count   <= drop_count_next;
      repeat_shift <= repeat_shift_next;
      drop_shift   <= drop_shift_next;
      src_flags    <= src_flags_next;
      max_fill     <= max_fill_next;
      clr_addr     <= clr_addr_next;
      clr_reply    <= clr_reply_next;
      wb_valid     <= wb_valid_next;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    cmd_q   <= cmd_q_next;
    res     <= res_next;
    copies  <= copies_next;
    side    <= side_next;
    acc     <= acc_next;
    wb_addr <= wb_addr_next;
    wb_val  <= wb_val_next;
  end

  // Checks
  a_no_rw_same_slot: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re && state != pvmr_pkg::ST_CLEAR) |-> (ram_waddr != ram_raddr))
    else $error("store read and writeback hit the same slot");

  a_sweep_owns_port: assert property (@(posedge clk) disable iff (rst)
    (state == pvmr_pkg::ST_CLEAR) |-> !wb_valid)
    else $error("writeback pending during clearing sweep");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    32'(write_slot) <= 32'(pvmr_pkg::BLOCK_BYTES))
    else $error("write slot past end of block");

  a_right_side_stereo: assert property (@(posedge clk) disable iff (rst)
    (state == pvmr_pkg::ST_ISSUE && side) |-> cfg.two_channel)
    else $error("right slot issued for mono output");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(max_fill) <= 32'(pvmr_pkg::BLOCK_BYTES))
    else $error("fill beyond block size");

endmodule
